@@ design/lvsvp_pkg.sv @@
// ----------------------------------------------------------------------------
// lvsvp_pkg
// Shared types and constants for the last value / stride value predictor.
// ----------------------------------------------------------------------------
package lvsvp_pkg;

	// Table depth. It must be a power of two, from 2 to 65536.
	localparam int ENTRIES = 1024;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int DATA_W  = 32;
	localparam int MODE_W  = 3;

	// Predictor modes. Codes 6 and 7 act as zero mode.
	typedef enum logic [MODE_W-1:0] {
		MODE_ZERO   = 3'd0,
		MODE_GLOBAL = 3'd1,
		MODE_PC     = 3'd2,
		MODE_PC_DA  = 3'd3,
		MODE_PC_BH  = 3'd4,
		MODE_STRIDE = 3'd5
	} mode_t;

	localparam mode_t MODE_RESET = MODE_PC;

	// Top-level control states
	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	typedef logic [IDX_W-1:0] idx_t;

	// One table entry: latest and older value for one slot
	typedef struct packed {
		logic [DATA_W-1:0] older;
		logic [DATA_W-1:0] latest;
	} entry_t;

	// Write request to the table
	typedef struct packed {
		logic   en;
		idx_t   idx;
		entry_t data;
	} tbl_wr_t;

	typedef struct packed {
		logic              command;
		logic [DATA_W-1:0] instr_address;
		logic [DATA_W-1:0] data_address;
		logic [DATA_W-1:0] branch_history;
		logic [DATA_W-1:0] actual_value;
	} in_item_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] predicted_value;
	} out_item_t;

endpackage

@@ design/lvsvp_table.sv @@
// ----------------------------------------------------------------------------
// lvsvp_table
// Prediction table: one entry per slot holding the latest and older value.
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lvsvp_table
	import lvsvp_pkg::*;
(
	input  logic    clk,
	input  logic    rd_en,
	input  idx_t    rd_idx,
	output entry_t  rd_data,
	input  tbl_wr_t wr
);

	entry_t mem [ENTRIES];
	entry_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
	end

	// Read port, old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/last_value_stride_value_predictor.sv @@
// Path: an accepted item is held in stage 1 while the table is read, then its result is
// loaded into the output register. Throughput: one item per cycle while results are taken;
// the single table read port, read at acceptance with forwarding of the write in flight,
// sets that rate. Reset: mode returns to per-pc last value, global last value to zero, and
// all ENTRIES (1024) table entries are cleared one entry per cycle, with no item taken.
// ----------------------------------------------------------------------------
// last_value_stride_value_predictor
// Load value predictor with zero, global last, per-entry last value and stride modes.
// ----------------------------------------------------------------------------
module last_value_stride_value_predictor
	import lvsvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item
);

	state_t            state_q, state_d;
	idx_t              clr_idx_q;
	mode_t             mode_q;
	logic [DATA_W-1:0] global_last_q;

	logic              accept;
	logic              advance;
	logic              busy_s1;
	in_item_t          item_s1;
	idx_t              idx_s1;
	logic              fwd_s1;
	entry_t            fwd_data_s1;

	logic [DATA_W-1:0] key;
	idx_t              rd_idx;
	entry_t            rd_data;
	entry_t            cur_entry;
	logic [DATA_W-1:0] pred;
	tbl_wr_t           tbl_wr;
	logic              fwd_d;

	logic              out_valid_q;
	out_item_t         out_q;

	// Clear sweep, then run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == {IDX_W{1'b1}}) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN:   state_d = ST_RUN;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	// Handshake: take a new item when the stage is empty or drains this cycle
	assign advance  = busy_s1 && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_RUN) && (!busy_s1 || advance);
	assign accept   = in_valid && in_ready;

	// Form the table index from the mode's key
	always_comb begin
		case (mode_q)
			MODE_PC_DA: key = in_item.instr_address ^ in_item.data_address;
			MODE_PC_BH: key = in_item.instr_address ^ in_item.branch_history;
			default:    key = in_item.instr_address;
		endcase
	end

	assign rd_idx = key[IDX_W+1:2];

	lvsvp_table u_table (
		.clk     (clk),
		.rd_en   (accept),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.wr      (tbl_wr)
	);

	// Catch a write to the entry being read in the same cycle
	assign fwd_d = tbl_wr.en && (tbl_wr.idx == rd_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
			fwd_s1  <= fwd_d;
		end else if (advance) begin
			busy_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_item;
			idx_s1      <= rd_idx;
			fwd_data_s1 <= tbl_wr.data;
		end
	end

	assign cur_entry = fwd_s1 ? fwd_data_s1 : rd_data;

	// Predict
	always_comb begin
		case (mode_q)
			MODE_GLOBAL: pred = global_last_q;
			MODE_PC, MODE_PC_DA, MODE_PC_BH: pred = cur_entry.latest;
			MODE_STRIDE: pred = {cur_entry.latest[DATA_W-2:0], 1'b0} - cur_entry.older;
			default:     pred = '0;
		endcase
	end

	// Table write: clear sweep, or update of the item in stage 1
	always_comb begin
		tbl_wr.en   = 1'b0;
		tbl_wr.idx  = idx_s1;
		tbl_wr.data = cur_entry;
		if (state_q == ST_CLEAR) begin
			tbl_wr.en   = 1'b1;
			tbl_wr.idx  = clr_idx_q;
			tbl_wr.data = '0;
		end else if (advance && item_s1.command) begin
			if (mode_q inside {MODE_PC, MODE_PC_DA, MODE_PC_BH}) begin
				tbl_wr.en          = 1'b1;
				tbl_wr.data.latest = item_s1.actual_value;
			end else if (mode_q == MODE_STRIDE) begin
				tbl_wr.en          = 1'b1;
				tbl_wr.data.older  = cur_entry.latest;
				tbl_wr.data.latest = item_s1.actual_value;
			end
		end
	end

	// Global last value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_last_q <= '0;
		end else if (advance && item_s1.command && (mode_q == MODE_GLOBAL)) begin
			global_last_q <= item_s1.actual_value;
		end
	end

	// Output register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.hit             <= (pred == item_s1.actual_value);
			out_q.predicted_value <= pred;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTH
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("item accepted during table clear");

	a_advance_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after stage advance");

	a_run_write_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		(tbl_wr.en && (state_q == ST_RUN)) |-> (busy_s1 && item_s1.command))
		else $error("table written without an update item");

	a_fwd_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> busy_s1)
		else $error("forward flag set with empty stage");
`endif

endmodule

@@ tb/tb_last_value_stride_value_predictor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_last_value_stride_value_predictor
// Self-checking bench for the load value predictor. A queue-fed driver offers
// load items, a monitor predicts each accepted item in every mode and compares
// each result with the oldest prediction. Both handshake sides idle at random
// in phases, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_last_value_stride_value_predictor;
	import lvsvp_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE6   = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7   = 3'd7;
	localparam logic              CMD_CHECK     = 1'b0;
	localparam logic              CMD_UPDATE    = 1'b1;
	localparam logic [DATA_W-1:0] STRIDE_FACTOR = 2;
	localparam int                POOL          = 16;
	localparam int                LONG_HOLD     = 400;
	localparam int                BATCH         = 100;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [MODE_W-1:0] cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_item_t          in_item   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_item;

	// Loads waiting to be offered, and results predicted but not yet seen
	in_item_t  pending_loads[$];
	out_item_t predicted_results[$];
	int        offered  = 0;
	int        accepted = 0;
	int        errors   = 0;

	// Idle rates and the long hold-off request
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_trigger  = 1'b0;
	bit hold_seen     = 1'b0;
	int hold_left     = 0;

	// Predictor state
	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] global_last_q;
	logic [DATA_W-1:0] latest_q[ENTRIES];
	logic [DATA_W-1:0] older_q[ENTRIES];

	// Stimulus pools: per-slot address, value sequence and step
	logic [DATA_W-1:0] pool_pc[POOL];
	logic [DATA_W-1:0] pool_da[POOL];
	logic [DATA_W-1:0] pool_bh[POOL];
	logic [DATA_W-1:0] seq_val[POOL];
	logic [DATA_W-1:0] seq_step[POOL];

	last_value_stride_value_predictor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	function automatic idx_t slot_of(logic [DATA_W-1:0] key);
		return key[IDX_W+1:2];
	endfunction

	// Form the prediction for one load and apply its update
	function automatic out_item_t load_value_predict(in_item_t ld);
		out_item_t         res;
		idx_t              slot;
		logic [DATA_W-1:0] guess;
		guess = '0;
		case (mode_q)
			MODE_GLOBAL: begin
				guess = global_last_q;
				if (ld.command)
					global_last_q = ld.actual_value;
			end
			MODE_PC, MODE_PC_DA, MODE_PC_BH: begin
				if (mode_q == MODE_PC)
					slot = slot_of(ld.instr_address);
				else if (mode_q == MODE_PC_DA)
					slot = slot_of(ld.instr_address ^ ld.data_address);
				else
					slot = slot_of(ld.instr_address ^ ld.branch_history);
				guess = latest_q[slot];
				if (ld.command)
					latest_q[slot] = ld.actual_value;
			end
			MODE_STRIDE: begin
				slot = slot_of(ld.instr_address);
				guess = STRIDE_FACTOR * latest_q[slot] - older_q[slot];
				if (ld.command) begin
					older_q[slot] = latest_q[slot];
					latest_q[slot] = ld.actual_value;
				end
			end
			default: guess = '0;
		endcase
		res.hit = (guess == ld.actual_value);
		res.predicted_value = guess;
		return res;
	endfunction

	task automatic push_load(logic cmd, logic [DATA_W-1:0] pc, logic [DATA_W-1:0] da,
			logic [DATA_W-1:0] bh, logic [DATA_W-1:0] val);
		in_item_t ld;
		ld.command = cmd;
		ld.instr_address = pc;
		ld.data_address = da;
		ld.branch_history = bh;
		ld.actual_value = val;
		pending_loads.insert(pending_loads.size(), ld);
	endtask

	// Mostly per-slot value sequences so that predictions hit; the rest is noise
	task automatic push_random_load();
		int                k;
		logic              cmd;
		logic [DATA_W-1:0] pc;
		logic [DATA_W-1:0] da;
		logic [DATA_W-1:0] bh;
		logic [DATA_W-1:0] val;
		k = $urandom_range(POOL - 1);
		pc = pool_pc[k];
		if ($urandom_range(3) == 0)
			pc[DATA_W-1:IDX_W+2] = (DATA_W-IDX_W-2)'($urandom());
		pc[1:0] = 2'($urandom_range(3));
		if ($urandom_range(1)) begin
			da = pool_da[k];
			bh = pool_bh[k];
		end else begin
			da = $urandom();
			bh = $urandom();
		end
		if ($urandom_range(99) < 75) begin
			val = seq_val[k];
			cmd = ($urandom_range(9) != 0) ? CMD_UPDATE : CMD_CHECK;
			if (cmd == CMD_UPDATE)
				seq_val[k] = seq_val[k] + seq_step[k];
		end else begin
			val = $urandom();
			cmd = $urandom_range(1) ? CMD_UPDATE : CMD_CHECK;
		end
		push_load(cmd, pc, da, bh, val);
	endtask

	// Wait until every load is offered, taken and answered, then let the pipe empty
	task automatic settle();
		while (pending_loads.size() != 0 || accepted != offered ||
				predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(logic [MODE_W-1:0] m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idle(int send_pct, int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic run_batch(logic [MODE_W-1:0] m, bit long_hold);
		set_mode(m);
		repeat (BATCH) push_random_load();
		if (long_hold) begin
			@(posedge clk);
			hold_trigger = ~hold_trigger;
		end
	endtask

	// Driver: hold an offered item until taken, else offer the next or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && accepted != offered) begin
			in_valid <= 1'b1;
		end else if (pending_loads.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			in_item <= pending_loads[0];
			pending_loads.delete(0);
			in_valid <= 1'b1;
			offered++;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here
	always @(negedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: track the mode, predict accepted loads, check results in order
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			mode_q = MODE_RESET;
			global_last_q = '0;
			for (int i = 0; i < ENTRIES; i++) begin
				latest_q[i] = '0;
				older_q[i] = '0;
			end
		end else begin
			if (cfg_we)
				mode_q = cfg_wdata;
			if (in_valid && in_ready) begin
				predicted_results.insert(predicted_results.size(),
					load_value_predict(in_item));
				accepted++;
			end
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: hit %0b value %08h",
							out_item.hit, out_item.predicted_value);
					errors++;
				end else begin
					want = predicted_results[0];
					predicted_results.delete(0);
					if (out_item.hit !== want.hit ||
							out_item.predicted_value !== want.predicted_value) begin
						if (errors < 10)
							$display("mismatch: expected hit %0b value %08h, got hit %0b value %08h",
								want.hit, want.predicted_value,
								out_item.hit, out_item.predicted_value);
						errors++;
					end
				end
			end
		end
	end

	// Stimulus sequence
	initial begin
		for (int k = 0; k < POOL; k++) begin
			pool_pc[k] = $urandom();
			pool_da[k] = $urandom();
			pool_bh[k] = $urandom();
			seq_val[k] = $urandom();
			seq_step[k] = (k < 4) ? '0 : $urandom();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Wait out the table clear
		@(posedge clk);
		while (!in_ready) @(posedge clk);

		set_idle(28, 70);

		// Reset mode: cleared table, forwarding, low bits and aliasing
		push_load(CMD_CHECK, 32'h0000_0000, 32'h0, 32'h0, 32'h0000_0000);
		push_load(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_load(CMD_UPDATE, 32'h0000_0100, 32'h0, 32'h0, 32'hDEAD_BEEF);
		push_load(CMD_CHECK, 32'h0000_0100, 32'h0, 32'h0, 32'hDEAD_BEEF);
		push_load(CMD_UPDATE, 32'h0000_0100, 32'h0, 32'h0, 32'h1234_5678);
		push_load(CMD_UPDATE, 32'h0000_0100, 32'h0, 32'h0, 32'h0000_0000);
		push_load(CMD_CHECK, 32'h0000_0103, 32'h0, 32'h0, 32'h0000_0000);
		push_load(CMD_CHECK, 32'h0000_0100 + (ENTRIES << 2), 32'h0, 32'h0, 32'h0);

		// Shared table across the three keyed last-value modes
		set_mode(MODE_PC_DA);
		push_load(CMD_UPDATE, 32'h0000_0100, 32'h0, 32'h0, 32'hA5A5_A5A5);
		push_load(CMD_CHECK, 32'h0000_0000, 32'h0000_0100, 32'h0, 32'hA5A5_A5A5);
		set_mode(MODE_PC_BH);
		push_load(CMD_CHECK, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FEFF, 32'hA5A5_A5A5);
		push_load(CMD_UPDATE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FEFF, 32'hFFFF_FFFF);

		// Stride: older takes latest, wraps modulo 2^32, shares latest
		set_mode(MODE_STRIDE);
		push_load(CMD_UPDATE, 32'h0000_0200, 32'h0, 32'h0, 32'd10);
		push_load(CMD_UPDATE, 32'h0000_0200, 32'h0, 32'h0, 32'd30);
		push_load(CMD_CHECK, 32'h0000_0200, 32'h0, 32'h0, 32'd50);
		push_load(CMD_UPDATE, 32'h0000_0200, 32'h0, 32'h0, 32'd0);
		push_load(CMD_CHECK, 32'h0000_0200, 32'h0, 32'h0, 32'hFFFF_FFE2);
		push_load(CMD_CHECK, 32'h0000_0100, 32'h0, 32'h0, 32'hFFFF_FFFE);

		set_mode(MODE_GLOBAL);
		push_load(CMD_CHECK, 32'h0000_0300, 32'h0, 32'h0, 32'h0000_0000);
		push_load(CMD_UPDATE, 32'h0000_0300, 32'h0, 32'h0, 32'hFFFF_FFFF);
		push_load(CMD_CHECK, 32'h0000_0400, 32'h0, 32'h0, 32'hFFFF_FFFF);

		// Zero mode and the unused codes write nothing
		set_mode(MODE_ZERO);
		push_load(CMD_UPDATE, 32'h0000_0100, 32'h0, 32'h0, 32'd5);
		set_mode(MODE_SPARE7);
		push_load(CMD_UPDATE, 32'h0000_0100, 32'h0, 32'h0, 32'd0);
		set_mode(MODE_SPARE6);
		push_load(CMD_UPDATE, 32'h0000_0100, 32'h0, 32'h0, 32'd7);
		set_mode(MODE_PC);
		push_load(CMD_CHECK, 32'h0000_0100, 32'h0, 32'h0, 32'hFFFF_FFFF);

		// Random phases
		run_batch(MODE_PC, 1'b0);
		run_batch(MODE_STRIDE, 1'b0);
		run_batch(MODE_GLOBAL, 1'b0);
		settle();
		set_idle(70, 28);
		run_batch(MODE_PC_DA, 1'b0);
		run_batch(MODE_PC_BH, 1'b0);
		run_batch(MODE_SPARE7, 1'b0);
		settle();
		set_idle(0, 0);
		run_batch(MODE_STRIDE, 1'b1);
		run_batch(MODE_ZERO, 1'b0);
		run_batch(MODE_SPARE6, 1'b0);
		settle();

		repeat (10) @(posedge clk);
		if (errors == 0 && predicted_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
